// ===== rtl/core/iomcu_pkg.sv =====
// shared types and constants of the i/o monitor and command unit
// used by every module under rtl/core
package iomcu_pkg;

    localparam int unsigned DefAnalogChannels = 8;
    localparam int unsigned DefSampleBits     = 10;
    localparam int unsigned QueueDepth        = 4;

    localparam logic [1:0] ACT_HOST = 2'd0;
    localparam logic [1:0] ACT_PORT = 2'd1;
    localparam logic [1:0] ACT_ADC  = 2'd2;
    localparam logic [1:0] ACT_TICK = 2'd3;

    localparam logic [1:0] KIND_HOST = 2'd0;
    localparam logic [1:0] KIND_ACT  = 2'd1;
    localparam logic [1:0] KIND_SCAN = 2'd2;

    localparam logic [1:0] PEND_NONE   = 2'd0;
    localparam logic [1:0] PEND_PERIOD = 2'd1;
    localparam logic [1:0] PEND_LEVEL  = 2'd2;

    localparam logic [3:0] OP_READ_LINE = 4'd0;
    localparam logic [3:0] OP_ACT_SET   = 4'd1;
    localparam logic [3:0] OP_ACT_RESET = 4'd2;
    localparam logic [3:0] OP_DW_SET    = 4'd3;
    localparam logic [3:0] OP_DW_CLR    = 4'd4;
    localparam logic [3:0] OP_AW_SET    = 4'd5;
    localparam logic [3:0] OP_AW_CLR    = 4'd6;
    localparam logic [3:0] OP_PORT      = 4'd7;
    localparam logic [3:0] OP_PERIOD    = 4'd8;
    localparam logic [3:0] OP_LEVEL     = 4'd9;
    localparam logic [3:0] OP_LATEST    = 4'd12;
    localparam logic [3:0] OP_MIN       = 4'd13;
    localparam logic [3:0] OP_MAX       = 4'd14;
    localparam logic [3:0] OP_PING      = 4'd15;

    // job kinds handed from front to back
    localparam logic [2:0] JOB_BYTE1 = 3'd0; // one byte, b0
    localparam logic [2:0] JOB_BYTE2 = 3'd1; // two bytes, b0 b1
    localparam logic [2:0] JOB_VAL3  = 3'd2; // head b0, value high, value low
    localparam logic [2:0] JOB_ACT   = 3'd3; // actuator request
    localparam logic [2:0] JOB_ACTE  = 3'd4; // error 1 then actuator request
    localparam logic [2:0] JOB_SCAN  = 3'd5; // scan request
    localparam logic [2:0] JOB_DIFF  = 3'd6; // changed watched lines

    localparam logic [15:0] PERIOD_RESET = 16'd1500;
    localparam logic [7:0]  LEVEL_SET    = 8'd100;
    localparam logic [7:0]  LEVEL_MAXOK  = 8'd201;
    localparam logic [7:0]  ERR_BASE     = 8'd160;
    localparam logic [7:0]  ERR_ARG      = 8'd1;
    localparam logic [7:0]  ERR_RX       = 8'd6;

    typedef struct packed {
        logic [2:0]  job;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [15:0] value; // value for JOB_VAL3, port for JOB_DIFF
        logic [15:0] mask;  // changed watched lines for JOB_DIFF
    } t_job;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [3:0] act_channel;
        logic [7:0] act_level;
        logic       last;
    } t_result;

endpackage

// ===== rtl/core/iomcu_queue.sv =====
// short job queue between front and back
// depends on iomcu_pkg
module iomcu_queue import iomcu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_job o_job
);
    localparam int unsigned AW = $clog2(QueueDepth);

    t_job            r_mem [QueueDepth];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule

// ===== rtl/core/iomcu_front.sv =====
// front end: decodes input words, keeps all monitor state, emits jobs
// depends on iomcu_pkg
module iomcu_front import iomcu_pkg::*; #(
    parameter int unsigned ANALOG_CHANNELS = DefAnalogChannels,
    parameter int unsigned SAMPLE_BITS     = DefSampleBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_host_byte,
    input  logic        i_rx_error,
    input  logic [15:0] i_port_sample,
    input  logic [2:0]  i_channel,
    input  logic [9:0]  i_sample_value,
    output logic        o_push,
    output t_job        o_job
);
    localparam int unsigned CW = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1;
    localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

    logic [1:0]  r_pend;
    logic [3:0]  r_pnib;
    logic [15:0] r_din, r_dwatch, r_period, r_tick;
    logic [ANALOG_CHANNELS-1:0] r_awatch;
    logic [SAMPLE_BITS-1:0] r_amax [ANALOG_CHANNELS];
    logic [SAMPLE_BITS-1:0] r_amin [ANALOG_CHANNELS];
    logic [SAMPLE_BITS-1:0] r_alat [ANALOG_CHANNELS];

    logic [3:0]  op, p;
    logic        p_ok, s_ok;
    logic [CW-1:0] pi, si;
    logic [SAMPLE_BITS-1:0] sv;
    logic [15:0] chg, nper;

    always_comb begin
        op   = i_host_byte[7:4];
        p    = i_host_byte[3:0];
        p_ok = ({28'd0, p} < 32'(ANALOG_CHANNELS));
        s_ok = ({29'd0, i_channel} < 32'(ANALOG_CHANNELS));
        pi   = CW'(p);
        si   = CW'(i_channel);
        sv   = SAMPLE_BITS'(i_sample_value);
        chg  = (i_port_sample ^ r_din) & r_dwatch;
        nper = 16'({r_pnib, i_host_byte, 4'd0} + 16'd10);
    end

    // job decode
    always_comb begin
        o_push = 1'b0;
        o_job  = '0;
        if (i_valid) begin
            unique case (i_action)
                ACT_HOST: begin
                    o_push = 1'b1;
                    if (i_rx_error) begin
                        o_job.b0 = ERR_BASE + ERR_RX;
                    end else if (r_pend == PEND_PERIOD) begin
                        o_job.b0 = 8'd128;
                    end else if (r_pend == PEND_LEVEL) begin
                        o_job.job = (i_host_byte > LEVEL_MAXOK) ? JOB_ACTE : JOB_ACT;
                        o_job.b0  = {4'd0, r_pnib};
                        o_job.b1  = i_host_byte;
                    end else begin
                        unique case (op)
                            OP_READ_LINE: begin
                                o_job.job = JOB_BYTE2;
                                o_job.b0  = {4'd0, p};
                                o_job.b1  = {7'd0, r_din[p]};
                            end
                            OP_ACT_SET: begin
                                o_job.job = JOB_ACT;
                                o_job.b0  = {4'd0, p};
                                o_job.b1  = LEVEL_SET;
                            end
                            OP_ACT_RESET: begin
                                o_job.job = JOB_ACT;
                                o_job.b0  = {4'd0, p};
                            end
                            OP_DW_SET: o_job.b0 = 8'd48 + {4'd0, p};
                            OP_DW_CLR: o_job.b0 = 8'd64 + {4'd0, p};
                            OP_AW_SET: o_job.b0 = p_ok ? 8'd80 + {4'd0, p} : ERR_BASE + ERR_ARG;
                            OP_AW_CLR: o_job.b0 = p_ok ? 8'd96 + {4'd0, p} : ERR_BASE + ERR_ARG;
                            OP_PORT: begin
                                o_job.job   = JOB_VAL3;
                                o_job.b0    = 8'd112;
                                o_job.value = r_din;
                            end
                            OP_PERIOD, OP_LEVEL: o_push = 1'b0;
                            OP_LATEST, OP_MIN, OP_MAX: begin
                                if (!p_ok) begin
                                    o_job.b0 = ERR_BASE + ERR_ARG;
                                end else begin
                                    o_job.job = JOB_VAL3;
                                    if (op == OP_LATEST) begin
                                        o_job.b0    = 8'd192 + {4'd0, p};
                                        o_job.value = 16'(r_alat[pi]);
                                    end else if (op == OP_MIN) begin
                                        o_job.b0    = 8'd208 + {4'd0, p};
                                        o_job.value = 16'(r_amin[pi]);
                                    end else begin
                                        o_job.b0    = 8'd224 + {4'd0, p};
                                        o_job.value = 16'(r_amax[pi]);
                                    end
                                end
                            end
                            OP_PING: o_job.b0 = 8'd240;
                            default: o_job.b0 = ERR_BASE + ERR_ARG;
                        endcase
                    end
                end
                ACT_PORT: begin
                    o_push      = (chg != '0);
                    o_job.job   = JOB_DIFF;
                    o_job.value = i_port_sample;
                    o_job.mask  = chg;
                end
                ACT_ADC: begin
                    o_push      = s_ok && r_awatch[si];
                    o_job.job   = JOB_VAL3;
                    o_job.b0    = 8'd192 + {5'd0, i_channel};
                    o_job.value = 16'(sv);
                end
                default: begin
                    o_push    = (r_tick == r_period);
                    o_job.job = JOB_SCAN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= PEND_NONE;
            r_pnib   <= '0;
            r_din    <= '0;
            r_dwatch <= '0;
            r_awatch <= '0;
            r_period <= PERIOD_RESET;
            r_tick   <= '0;
            for (int i = 0; i < ANALOG_CHANNELS; i++) begin
                r_amax[i] <= '0;
                r_amin[i] <= SMAX;
                r_alat[i] <= '0;
            end
        end else if (i_valid) begin
            unique case (i_action)
                ACT_HOST: begin
                    r_pend <= PEND_NONE;
                    if (!i_rx_error) begin
                        if (r_pend == PEND_PERIOD) begin
                            r_period <= nper;
                            r_tick   <= nper;
                        end else if (r_pend != PEND_LEVEL) begin
                            unique case (op)
                                OP_DW_SET: r_dwatch[p] <= 1'b1;
                                OP_DW_CLR: r_dwatch[p] <= 1'b0;
                                OP_AW_SET: if (p_ok) r_awatch[pi] <= 1'b1;
                                OP_AW_CLR: if (p_ok) r_awatch[pi] <= 1'b0;
                                OP_PERIOD: begin
                                    r_pend <= PEND_PERIOD;
                                    r_pnib <= p;
                                end
                                OP_LEVEL: begin
                                    r_pend <= PEND_LEVEL;
                                    r_pnib <= p;
                                end
                                OP_MIN: if (p_ok) r_amin[pi] <= r_alat[pi];
                                OP_MAX: if (p_ok) r_amax[pi] <= r_alat[pi];
                                default: ;
                            endcase
                        end
                    end
                end
                ACT_PORT: r_din <= i_port_sample;
                ACT_ADC: begin
                    if (s_ok) begin
                        r_alat[si] <= sv;
                        if (sv > r_amax[si]) r_amax[si] <= sv;
                        if (sv < r_amin[si]) r_amin[si] <= sv;
                    end
                end
                default: begin
                    r_tick <= (r_tick == r_period) ? 16'd1 : r_tick + 16'd1;
                end
            endcase
        end
    end
endmodule

// ===== rtl/core/iomcu_back.sv =====
// back end: turns one job into its sequence of result words
// depends on iomcu_pkg
module iomcu_back import iomcu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);
    logic [1:0]  r_step;   // word index inside the job
    logic [15:0] r_done;   // diff lines already reported
    logic        r_half;   // diff: 0 line number, 1 level
    logic        r_ovalid;
    t_result     r_ores;

    t_result res;
    logic    fin, adv;
    logic [15:0] rem, low;
    logic [3:0]  lid;

    always_comb begin
        rem = i_job.mask & ~r_done;
        low = rem & (~rem + 16'd1);
        lid = '0;
        for (int i = 0; i < 16; i++) if (low[i]) lid = 4'(i);
    end

    always_comb begin
        res = '0;
        fin = 1'b1;
        unique case (i_job.job)
            JOB_BYTE2: begin
                res.out_byte = (r_step == 2'd0) ? i_job.b0 : i_job.b1;
                fin = (r_step == 2'd1);
            end
            JOB_VAL3: begin
                res.out_byte = (r_step == 2'd0) ? i_job.b0 :
                               (r_step == 2'd1) ? i_job.value[15:8] : i_job.value[7:0];
                fin = (r_step == 2'd2);
            end
            JOB_ACT: begin
                res.kind = KIND_ACT;
                res.act_channel = i_job.b0[3:0];
                res.act_level = i_job.b1;
            end
            JOB_ACTE: begin
                if (r_step == 2'd0) begin
                    res.out_byte = ERR_BASE + ERR_ARG;
                    fin = 1'b0;
                end else begin
                    res.kind = KIND_ACT;
                    res.act_channel = i_job.b0[3:0];
                    res.act_level = i_job.b1;
                end
            end
            JOB_SCAN: res.kind = KIND_SCAN;
            JOB_DIFF: begin
                res.out_byte = r_half ? {7'd0, i_job.value[lid]} : {4'd0, lid};
                fin = r_half && ((rem & ~low) == '0);
            end
            default: res.out_byte = i_job.b0;
        endcase
        res.last = fin;
    end

    assign adv     = !i_empty && (!r_ovalid || i_ready);
    assign o_pop   = adv && fin;
    assign o_valid = r_ovalid;
    assign o_res   = r_ores;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_done   <= '0;
            r_half   <= 1'b0;
        end else begin
            if (adv) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (adv) begin
                if (fin) begin
                    r_step <= '0;
                    r_done <= '0;
                    r_half <= 1'b0;
                end else begin
                    r_step <= r_step + 2'd1;
                    r_half <= !r_half;
                    if (r_half) r_done <= r_done | low;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_ores <= res;
    end
endmodule

// ===== rtl/core/io_monitor_command_unit.sv =====
// top level of the i/o monitor and command unit
// depends on iomcu_pkg, iomcu_front, iomcu_queue, iomcu_back
//
// usage:
//  - slave stream carries one input word per handshake: host byte, digital
//    port sample, analog sample or timer tick (selector in s_axis_tuser)
//  - master stream gives result words: host bytes, actuator requests and
//    scan requests, m_axis_tlast on the final word caused by one input
//  - the front decodes a word in the cycle it is taken and updates all
//    monitor state at once; one input word per cycle unless the queue is full
//  - it pushes at most one job into a four-entry queue; the back expands a
//    job into 1 to 32 result words, one per cycle unless the receiver stalls
//  - with an empty queue, a job passes the queue and the output register
//  - when the receiver stalls, the back holds its output register and the
//    queue fills; s_axis_tready drops only when the queue is full
//  - reset clears watch masks and max/latest, sets min to all ones, period 1500
module io_monitor_command_unit import iomcu_pkg::*; #(
    parameter int unsigned ANALOG_CHANNELS = DefAnalogChannels,
    parameter int unsigned SAMPLE_BITS     = DefSampleBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // host_byte[7:0], rx_error[8], port_sample[24:9], channel[27:25],
    // sample_value[37:28], zero fill
    input  logic [39:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0], act_channel[11:8], act_level[19:12], zero fill
    output logic [23:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    logic    full, empty, push, pop, acc;
    t_job    fjob, qjob;
    t_result res;

    assign s_axis_tready = !full;
    assign acc = s_axis_tvalid && s_axis_tready;

    iomcu_front #(
        .ANALOG_CHANNELS(ANALOG_CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (acc),
        .i_action      (s_axis_tuser),
        .i_host_byte   (s_axis_tdata[7:0]),
        .i_rx_error    (s_axis_tdata[8]),
        .i_port_sample (s_axis_tdata[24:9]),
        .i_channel     (s_axis_tdata[27:25]),
        .i_sample_value(s_axis_tdata[37:28]),
        .o_push        (push),
        .o_job         (fjob)
    );

    iomcu_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (fjob),
        .o_full (full),
        .o_empty(empty),
        .i_pop  (pop),
        .o_job  (qjob)
    );

    iomcu_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_job  (qjob),
        .o_pop  (pop),
        .o_valid(m_axis_tvalid),
        .o_res  (res),
        .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, res.act_level, res.act_channel, res.out_byte};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

`ifndef ASSERT_OFF
    // queue never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push) else $error("job queue overflow");
    // a job is taken only from a non-empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("job queue underflow");
    // kind of a result word is never the unused code
    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_HOST || m_axis_tuser == KIND_ACT ||
                           m_axis_tuser == KIND_SCAN)) else $error("bad result kind");
`endif
endmodule
